// File: rtl/lzwhbe_pkg.sv
// shared constants, types and command/status bundles for the lzw byte encoder
`timescale 1ns / 1ps
package lzwhbe_pkg;
  localparam int HASH_ENTRIES  = 5003;
  localparam int MAX_CODE_BITS = 12;

  localparam int IDX_W   = $clog2(HASH_ENTRIES);
  localparam int CODE_W  = MAX_CODE_BITS;
  localparam int NFC_W   = MAX_CODE_BITS + 1;
  localparam int ACC_W   = MAX_CODE_BITS + 8;
  localparam int PEND_W  = 5;
  localparam int WIDTH_W = 4;
  localparam int ENTRY_W = 2 * CODE_W + 8;

  localparam logic [CODE_W-1:0]  CLEAR_CODE  = CODE_W'(256);
  localparam logic [CODE_W-1:0]  END_CODE    = CODE_W'(257);
  localparam logic [NFC_W-1:0]   FIRST_FREE  = NFC_W'(258);
  localparam logic [NFC_W-1:0]   FULL_CODE   = NFC_W'(1 << MAX_CODE_BITS);
  localparam logic [WIDTH_W-1:0] START_WIDTH = WIDTH_W'(9);
  localparam logic [WIDTH_W-1:0] MAX_WIDTH   = WIDTH_W'(MAX_CODE_BITS);
  localparam logic [NFC_W-1:0]   START_LIMIT = NFC_W'(511);

  // code source for an emit
  localparam logic [1:0] SEL_WAIT  = 2'd0;
  localparam logic [1:0] SEL_CLEAR = 2'd1;
  localparam logic [1:0] SEL_END   = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       hash;
    logic       rd;
    logic       step;
    logic       emit;
    logic [1:0] sel;
    logic       push;
    logic       last;
    logic       fin;
    logic       set_wait_byte;
    logic       set_wait_hit;
    logic       set_started;
    logic       wr_entry;
    logic       full_reset;
    logic       state_reset;
    logic       clr_start;
    logic       clr_en;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic started;
    logic empty;
    logic hit;
    logic probe_last;
    logic pend_ge8;
    logic pend_lt16;
    logic pend_eq8;
    logic pend_zero;
    logic full;
    logic clr_done;
    logic out_free;
  } status_t;
endpackage

// File: rtl/lzwhbe_dp.sv
// datapath: string table memory, hashing, probing, bit packing, output register
`timescale 1ns / 1ps
module lzwhbe_dp import lzwhbe_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          action,
  input  logic [7:0]    data_byte,
  input  cmd_t          cmd,
  output status_t       status,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          last_in_run,
  output logic          stream_end
);
  logic [ENTRY_W-1:0] mem [HASH_ENTRIES];
  logic [ENTRY_W-1:0] mem_q;
  logic [7:0]         byte_reg;
  logic [IDX_W-1:0]   k;
  logic [IDX_W-1:0]   probes;
  logic [IDX_W-1:0]   clr_addr;
  logic [CODE_W-1:0]  waiting;
  logic [NFC_W-1:0]   nfc;
  logic [WIDTH_W-1:0] width;
  logic [NFC_W-1:0]   limit;
  logic [ACC_W-1:0]   acc;
  logic [PEND_W-1:0]  pend;
  logic               started;

  logic [IDX_W:0]     hsum;
  logic [IDX_W-1:0]   hidx;
  logic [IDX_W-1:0]   disp;
  logic [IDX_W:0]     kstep;
  logic [IDX_W-1:0]   knext;
  logic [CODE_W-1:0]  code_sel;
  logic [CODE_W-1:0]  code_m;
  logic [WIDTH_W-1:0] width_up;

  localparam logic [IDX_W:0] ENTRIES_X = (IDX_W + 1)'(HASH_ENTRIES);

  assign hsum = (IDX_W + 1)'({byte_reg, {(MAX_CODE_BITS - 8){1'b0}}}) + (IDX_W + 1)'(waiting);
  assign hidx = (hsum >= ENTRIES_X) ? IDX_W'(hsum - ENTRIES_X) : hsum[IDX_W-1:0];

  assign disp  = (k == '0) ? IDX_W'(1) : IDX_W'(ENTRIES_X - {1'b0, k});
  assign kstep = (k >= disp) ? ({1'b0, k} - {1'b0, disp})
                             : ({1'b0, k} + ENTRIES_X - {1'b0, disp});
  assign knext = kstep[IDX_W-1:0];

  always_comb begin
    case (cmd.sel)
      SEL_CLEAR: code_sel = CLEAR_CODE;
      SEL_END:   code_sel = END_CODE;
      default:   code_sel = waiting;
    endcase
  end
  assign code_m   = code_sel & ~({CODE_W{1'b1}} << width);
  assign width_up = width + WIDTH_W'(1);

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr_entry) begin
      mem[k] <= {nfc[CODE_W-1:0], waiting, byte_reg};
    end
    if (cmd.rd) begin
      mem_q <= mem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) byte_reg <= data_byte;
    if (cmd.hash) begin
      k      <= hidx;
      probes <= '0;
    end else if (cmd.step) begin
      k      <= knext;
      probes <= probes + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.state_reset) begin
      waiting <= '0;
      nfc     <= FIRST_FREE;
      width   <= START_WIDTH;
      limit   <= START_LIMIT;
      acc     <= '0;
      pend    <= '0;
      started <= 1'b0;
    end else begin
      if (cmd.set_wait_byte) waiting <= CODE_W'(byte_reg);
      if (cmd.set_wait_hit)  waiting <= mem_q[ENTRY_W-1 -: CODE_W];
      if (cmd.set_started)   started <= 1'b1;
      if (cmd.wr_entry)      nfc <= nfc + NFC_W'(1);
      if (cmd.full_reset) begin
        nfc   <= FIRST_FREE;
        width <= START_WIDTH;
        limit <= START_LIMIT;
      end
      if (cmd.emit) begin
        acc  <= acc | (ACC_W'(code_m) << pend);
        pend <= pend + PEND_W'(width);
        if (nfc > limit && width < MAX_WIDTH) begin
          width <= width_up;
          limit <= (width_up == MAX_WIDTH) ? FULL_CODE : ~(NFC_W'({NFC_W{1'b1}}) << width_up);
        end
      end
      if (cmd.push) begin
        acc  <= acc >> 8;
        pend <= pend - PEND_W'(8);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_byte    <= acc[7:0];
      last_in_run <= cmd.last;
      stream_end  <= cmd.last & cmd.fin;
    end
  end

  always_comb begin
    status.action     = action;
    status.started    = started;
    status.empty      = (mem_q[ENTRY_W-1 -: CODE_W] == '0);
    status.hit        = (mem_q[ENTRY_W-CODE_W-1 -: CODE_W] == waiting) &&
                        (mem_q[7:0] == byte_reg);
    status.probe_last = ({1'b0, probes} == ENTRIES_X);
    status.pend_ge8   = (pend >= PEND_W'(8));
    status.pend_lt16  = (pend < PEND_W'(16));
    status.pend_eq8   = (pend == PEND_W'(8));
    status.pend_zero  = (pend == '0);
    status.full       = (nfc >= FULL_CODE);
    status.clr_done   = (clr_addr == IDX_W'(HASH_ENTRIES - 1));
    status.out_free   = !out_valid || !out_stall;
  end
endmodule

// File: rtl/lzwhbe_ctrl.sv
// controller: sequences hashing, probing, code emission, draining and clearing
`timescale 1ns / 1ps
module lzwhbe_ctrl import lzwhbe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_EMIT  = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_PAD   = 4'd8;

  localparam logic [2:0] J_START = 3'd0;
  localparam logic [2:0] J_FIN1  = 3'd1;
  localparam logic [2:0] J_FIN2  = 3'd2;
  localparam logic [2:0] J_MISS  = 3'd3;
  localparam logic [2:0] J_FULL  = 3'd4;

  logic [3:0] state, state_next;
  logic [2:0] job, job_next;
  logic [1:0] sel, sel_next;
  logic       final_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      job   <= J_START;
      sel   <= SEL_WAIT;
    end else begin
      state <= state_next;
      job   <= job_next;
      sel   <= sel_next;
    end
  end

  assign in_stall = (state != S_IDLE);
  assign final_code = (job == J_START) || (job == J_FIN2) || (job == J_FULL) ||
                      ((job == J_MISS) && !status.full);

  always_comb begin
    state_next = state;
    job_next   = job;
    sel_next   = sel;
    cmd        = '0;
    cmd.sel    = sel;
    cmd.fin    = (job == J_FIN2);
    unique case (state)
      S_CLR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (status.action) begin
            job_next   = J_FIN1;
            sel_next   = status.started ? SEL_WAIT : SEL_CLEAR;
            state_next = S_EMIT;
          end else if (!status.started) begin
            job_next   = J_START;
            sel_next   = SEL_CLEAR;
            state_next = S_EMIT;
          end else begin
            state_next = S_HASH;
          end
        end
      end
      S_HASH: begin
        cmd.hash   = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (status.empty || (!status.hit && status.probe_last)) begin
          job_next   = J_MISS;
          sel_next   = SEL_WAIT;
          state_next = S_EMIT;
        end else if (status.hit) begin
          cmd.set_wait_hit = 1'b1;
          state_next       = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_RD;
        end
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (status.pend_ge8) begin
          if (status.out_free) begin
            cmd.push = 1'b1;
            cmd.last = final_code && status.pend_lt16 && !((job == J_FIN2) && !status.pend_eq8);
          end
        end else begin
          unique case (job)
            J_START: begin
              cmd.set_wait_byte = 1'b1;
              cmd.set_started   = 1'b1;
              state_next        = S_IDLE;
            end
            J_FIN1: begin
              job_next   = J_FIN2;
              sel_next   = SEL_END;
              state_next = S_EMIT;
            end
            J_FIN2: state_next = S_PAD;
            J_MISS: begin
              if (status.full) begin
                job_next   = J_FULL;
                sel_next   = SEL_CLEAR;
                state_next = S_EMIT;
              end else begin
                state_next = S_WR;
              end
            end
            default: begin
              cmd.full_reset    = 1'b1;
              cmd.set_wait_byte = 1'b1;
              cmd.clr_start     = 1'b1;
              state_next        = S_CLR;
            end
          endcase
        end
      end
      S_WR: begin
        cmd.wr_entry      = 1'b1;
        cmd.set_wait_byte = 1'b1;
        state_next        = S_IDLE;
      end
      S_PAD: begin
        if (status.pend_zero) begin
          cmd.state_reset = 1'b1;
          cmd.clr_start   = 1'b1;
          state_next      = S_CLR;
        end else if (status.out_free) begin
          cmd.push        = 1'b1;
          cmd.last        = 1'b1;
          cmd.state_reset = 1'b1;
          cmd.clr_start   = 1'b1;
          state_next      = S_CLR;
        end
      end
      default: state_next = S_CLR;
    endcase
  end
endmodule

// File: rtl/lzw_hashed_byte_encoder.sv
// top level of the hashed lzw byte encoder
`timescale 1ns / 1ps
// lzw byte encoder, gif style, codes of 9 to 12 bits packed lsb first
// input channel: in_valid / in_stall carry action and data_byte; a transfer
//   happens when in_valid is high and in_stall is low. action 0 compresses
//   data_byte, action 1 finishes the stream (waiting code, end code, pad)
// output channel: out_valid / out_stall carry out_byte, last_in_run and
//   stream_end, one packed byte per transfer, up to four per input item
// one item at a time: each probe is one registered read of the table's
//   single read port; each emitted code is then drained byte by byte into
//   the output register, and a miss writes a new table entry
// an emitted code is registered in the packer before its first byte is pushed
// reset and every finish run a clearing pass over all 5003 table entries,
//   one entry per cycle, while in_stall stays high; a full table triggers
//   the same pass
// a stalled receiver holds the output register and the byte drain waits
module lzw_hashed_byte_encoder import lzwhbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_in_run,
  output logic       stream_end
);
  cmd_t    cmd;
  status_t status;

  // sequencing of each item
  lzwhbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // table, packer and output register
  lzwhbe_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .action      (action),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_in_run (last_in_run),
    .stream_end  (stream_end)
  );

  // end of stream is always the last byte of its item
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> last_in_run)
    else $error("stream_end without last_in_run");

  // items are taken one at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> in_stall)
    else $error("input open right after reset");
endmodule

// File: test/tb_lzw_hashed_byte_encoder.sv
// self-checking testbench for the hashed lzw byte encoder
`timescale 1ns / 1ps

// one expected packed byte
typedef struct {
  logic [7:0] data;
  logic       last;
  logic       fin;
} packed_byte_t;

// mirrors the encoder state and keeps the packed bytes still owed by the block
class lzw_scoreboard;
  int unsigned  slot_code [lzwhbe_pkg::HASH_ENTRIES];
  int unsigned  slot_prefix [lzwhbe_pkg::HASH_ENTRIES];
  int unsigned  slot_suffix [lzwhbe_pkg::HASH_ENTRIES];
  int unsigned  wait_code, free_code, width, limit, acc, nbits;
  bit           started;
  packed_byte_t owed_bytes[$];
  packed_byte_t run[$];
  int           errors;

  function void clear_stream();
    foreach (slot_code[i]) begin
      slot_code[i] = 0;
      slot_prefix[i] = 0;
      slot_suffix[i] = 0;
    end
    wait_code = 0;
    free_code = 258;
    width = 9;
    limit = 511;
    acc = 0;
    nbits = 0;
    started = 0;
  endfunction

  function new();
    errors = 0;
    clear_stream();
  endfunction

  function void add_byte(int unsigned b);
    packed_byte_t p;
    if (run.size() >= 4) return;
    p.data = b[7:0];
    p.last = 0;
    p.fin = 0;
    run.push_back(p);
  endfunction

  // append one code of the current width and drain whole bytes
  function void add_code(int unsigned code);
    code &= (1 << width) - 1;
    acc = (acc | (code << nbits)) & 'hfffff;
    nbits += width;
    while (nbits >= 8) begin
      add_byte(acc & 'hff);
      acc >>= 8;
      nbits -= 8;
    end
    if (free_code > limit && width < lzwhbe_pkg::MAX_CODE_BITS) begin
      width++;
      limit = (width == lzwhbe_pkg::MAX_CODE_BITS) ? (1 << width) : (1 << width) - 1;
    end
  endfunction

  // returns 1 when the probed slot holds the waiting string extended by b
  function bit slot_hit(int unsigned k, int unsigned b);
    return slot_prefix[k] == wait_code && slot_suffix[k] == b;
  endfunction

  function void note_input(logic act, logic [7:0] b);
    int unsigned k, disp;
    bit found;
    run.delete();
    found = 0;
    if (act) begin
      add_code(started ? wait_code : int'(lzwhbe_pkg::CLEAR_CODE));
      add_code(lzwhbe_pkg::END_CODE);
      if (nbits > 0) add_byte(acc & 'hff);
      if (run.size() > 0) begin
        run[run.size()-1].last = 1;
        run[run.size()-1].fin = 1;
      end
      clear_stream();
    end else if (!started) begin
      add_code(lzwhbe_pkg::CLEAR_CODE);
      wait_code = b;
      started = 1;
    end else begin
      k = ((int'(b) << (lzwhbe_pkg::MAX_CODE_BITS - 8)) + wait_code) % lzwhbe_pkg::HASH_ENTRIES;
      if (slot_code[k] != 0) begin
        if (slot_hit(k, b)) found = 1;
        else begin
          disp = (k == 0) ? 1 : lzwhbe_pkg::HASH_ENTRIES - k;
          for (int i = 0; i < lzwhbe_pkg::HASH_ENTRIES; i++) begin
            k = (k >= disp) ? k - disp : k + lzwhbe_pkg::HASH_ENTRIES - disp;
            if (slot_code[k] == 0) break;
            if (slot_hit(k, b)) begin
              found = 1;
              break;
            end
          end
        end
      end
      if (found) wait_code = slot_code[k];
      else begin
        add_code(wait_code);
        if (free_code < (1 << lzwhbe_pkg::MAX_CODE_BITS)) begin
          slot_code[k] = free_code;
          slot_prefix[k] = wait_code;
          slot_suffix[k] = b;
          free_code++;
        end else begin
          foreach (slot_code[i]) slot_code[i] = 0;
          free_code = 258;
          add_code(lzwhbe_pkg::CLEAR_CODE);
          width = 9;
          limit = 511;
        end
        wait_code = b;
      end
    end
    if (!act && run.size() > 0) run[run.size()-1].last = 1;
    foreach (run[i]) owed_bytes.push_back(run[i]);
  endfunction

  function void check_result(logic [7:0] b, logic l, logic e);
    packed_byte_t x;
    if (owed_bytes.size() == 0) begin
      $error("unexpected output byte %0h", b);
      errors++;
      return;
    end
    x = owed_bytes.pop_front();
    if (b !== x.data) begin
      $error("out_byte expected %0h actual %0h", x.data, b);
      errors++;
    end
    if (l !== x.last) begin
      $error("last_in_run expected %0b actual %0b", x.last, l);
      errors++;
    end
    if (e !== x.fin) begin
      $error("stream_end expected %0b actual %0b", x.fin, e);
      errors++;
    end
  endfunction
endclass

module tb_lzw_hashed_byte_encoder;
  import lzwhbe_pkg::*;

  localparam int IDLE_LIMIT = 60000;

  logic       clk = 0;
  logic       rst = 1;
  logic       in_valid = 0;
  logic       in_stall;
  logic       action = 0;
  logic [7:0] data_byte = 0;
  logic       out_valid;
  logic       out_stall = 0;
  logic [7:0] out_byte;
  logic       last_in_run;
  logic       stream_end;

  lzw_scoreboard encoder_mirror = new();
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_span = 0;

  lzw_hashed_byte_encoder u_top (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // receiver: stall pattern switches between free running, light and heavy stalls
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(5, 60);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      default: out_stall <= ($urandom_range(0, 99) < 75);
    endcase
    if (!rst && out_valid && !out_stall)
      encoder_mirror.check_result(out_byte, last_in_run, stream_end);
  end

  // watchdog: any transfer on either side resets the idle count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // sender: one transfer, then maybe a gap when the burst runs out
  task automatic send_item(input logic act, input logic [7:0] b);
    in_valid <= 1;
    action <= act;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encoder_mirror.note_input(act, b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 0;
        data_byte <= 8'($urandom);
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_stream(input int len, input int alphabet);
    for (int i = 0; i < len; i++) send_item(0, 8'($urandom_range(0, alphabet - 1)));
    send_item(1, 8'($urandom));
  endtask

  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst <= 0;

    // directed: empty stream, single bytes at the extremes, repeats that hit the table
    send_item(1, 8'hff);
    send_item(0, 8'h00);
    send_item(1, 8'h00);
    send_item(0, 8'hff);
    send_item(1, 8'h5a);
    for (int i = 0; i < 8; i++) send_item(0, 8'hff);
    for (int i = 0; i < 6; i++) send_item(0, (i % 2) ? 8'h00 : 8'hff);
    send_item(1, 8'h00);

    // random short streams, mostly with a small alphabet so strings repeat
    n = 0;
    while (n < 180) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 35);
      send_stream(len, ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(2, 6));
      n += len + 1;
    end

    in_valid <= 0;
    while (encoder_mirror.owed_bytes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (encoder_mirror.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
